### hw/rtl/bbc_pkg.sv
package bbc_pkg;

    // Default alphabet size and the byte width carried on the stream
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int BYTE_W            = 8;
    localparam int MAP_FULL          = 1 << BYTE_W;

    // Result queue: depth is a power of two so the pointers wrap on their own
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // One input word after unpacking
    typedef struct packed {
        logic              last;
        logic              t_present;
        logic              s_present;
        logic [BYTE_W-1:0] t_byte;
        logic [BYTE_W-1:0] s_byte;
    } pair_t;

    // Verdict handed from the pair engine to the result queue
    typedef struct packed {
        logic valid;
        logic isomorphic;
    } res_push_t;

endpackage

### hw/rtl/byte_bijection_checker.sv
// Byte bijection checker: decides whether two byte strings are isomorphic.
// Each input word carries one position of both strings (s byte, t byte and a
// present flag for each); a word with tlast set closes the strings and yields
// one output word holding the verdict, while all other words yield nothing.
// One input word is taken every clock cycle while s_tready is high; the last
// word is registered in the stage-1 word register and its verdict then in the
// verdict queue before it is presented on m_tdata. The forward and backward maps
// live in two synchronous RAMs of ALPHABET_SIZE (at most 256) bytes that are
// read, checked and written back in a two-stage loop, with a bypass covering
// a word that maps the same byte as the word just before it. Valid bits sit in
// flip-flops and clear in the same cycle as the last word, so no clearing pass
// is needed after reset or between strings. s_tready falls only when the
// four-word verdict queue backs up behind a low m_tready.
module byte_bijection_checker import bbc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2*BYTE_W-1:0] s_tdata,   // [7:0] s_byte, [15:8] t_byte
    input  logic [1:0]          s_tuser,   // [0] s_present, [1] t_present
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata    // [0] isomorphic, [7:1] zero
);

    pair_t     item;
    res_push_t push;
    logic      accept;
    logic      last_pending;
    logic      space_ok;
    logic      isomorphic;

    // Unpack the input word
    assign accept         = s_tvalid && s_tready;
    assign item.s_byte    = s_tdata[BYTE_W-1:0];
    assign item.t_byte    = s_tdata[2*BYTE_W-1:BYTE_W];
    assign item.s_present = s_tuser[0];
    assign item.t_present = s_tuser[1];
    assign item.last      = s_tlast;
    assign s_tready       = space_ok;

    bbc_pair_engine #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .in_item      (item),
        .push         (push),
        .last_pending (last_pending)
    );

    bbc_result_fifo u_result
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .last_pending   (last_pending),
        .space_ok       (space_ok),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_isomorphic (isomorphic)
    );

    assign m_tdata = {{(BYTE_W-1){1'b0}}, isomorphic};

endmodule

### hw/rtl/bbc_ram.sv
module bbc_ram import bbc_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = MAP_FULL
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port; read during write returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/bbc_pair_engine.sv
module bbc_pair_engine import bbc_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  pair_t     in_item,
    output res_push_t push,
    output logic      last_pending
);

    localparam int MAP_DEPTH = (ALPHABET_SIZE < MAP_FULL) ? ALPHABET_SIZE : MAP_FULL;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);

    // Stage 1 word register
    logic  s1_valid_reg, s1_valid_next;
    pair_t s1_item_reg;

    // Map valid bits and sticky mismatch flag
    logic [MAP_DEPTH-1:0] fwd_valid_reg, fwd_valid_next;
    logic [MAP_DEPTH-1:0] bwd_valid_reg, bwd_valid_next;
    logic                 mismatch_reg, mismatch_next;

    // Bypass of the write made in the previous cycle (RAM read missed it)
    logic              fw_en_reg, fw_en_next;
    logic [ADDR_W-1:0] fw_s_addr_reg;
    logic [ADDR_W-1:0] fw_t_addr_reg;
    logic [BYTE_W-1:0] fw_s_byte_reg;
    logic [BYTE_W-1:0] fw_t_byte_reg;

    logic [ADDR_W-1:0] rd_s_addr, rd_t_addr;
    logic [ADDR_W-1:0] s_addr, t_addr;
    logic [BYTE_W-1:0] fwd_rdata, bwd_rdata;
    logic [BYTE_W-1:0] fwd_data, bwd_data;
    logic              fv, bv, s_in, t_in, both, in_range;
    logic              do_write, conflict, err, mism_now;

    assign rd_s_addr = in_item.s_byte[ADDR_W-1:0];
    assign rd_t_addr = in_item.t_byte[ADDR_W-1:0];
    assign s_addr    = s1_item_reg.s_byte[ADDR_W-1:0];
    assign t_addr    = s1_item_reg.t_byte[ADDR_W-1:0];

    // Forward map: s byte -> t byte
    bbc_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_fwd_ram
    (
        .clk   (clk),
        .we    (do_write),
        .waddr (s_addr),
        .wdata (s1_item_reg.t_byte),
        .re    (in_valid),
        .raddr (rd_s_addr),
        .rdata (fwd_rdata)
    );

    // Backward map: t byte -> s byte
    bbc_ram #(.WIDTH(BYTE_W), .DEPTH(MAP_DEPTH)) u_bwd_ram
    (
        .clk   (clk),
        .we    (do_write),
        .waddr (t_addr),
        .wdata (s1_item_reg.s_byte),
        .re    (in_valid),
        .raddr (rd_t_addr),
        .rdata (bwd_rdata)
    );

    // Check the pair against both maps
    always_comb
    begin
        s_in     = (ALPHABET_SIZE >= MAP_FULL) || (32'(s1_item_reg.s_byte) < ALPHABET_SIZE);
        t_in     = (ALPHABET_SIZE >= MAP_FULL) || (32'(s1_item_reg.t_byte) < ALPHABET_SIZE);
        both     = s1_item_reg.s_present && s1_item_reg.t_present;
        in_range = s_in && t_in;
        fv       = fwd_valid_reg[s_addr];
        bv       = bwd_valid_reg[t_addr];
        fwd_data = (fw_en_reg && fw_s_addr_reg == s_addr) ? fw_t_byte_reg : fwd_rdata;
        bwd_data = (fw_en_reg && fw_t_addr_reg == t_addr) ? fw_s_byte_reg : bwd_rdata;
        do_write = s1_valid_reg && both && in_range && !fv && !bv;
        conflict = both && in_range && (fv || bv) &&
                   !(fv && fwd_data == s1_item_reg.t_byte &&
                     bv && bwd_data == s1_item_reg.s_byte);
        err      = (s1_item_reg.s_present != s1_item_reg.t_present) ||
                   (both && !in_range) || conflict;
        mism_now = mismatch_reg || err;
    end

    // State update; last word gives the verdict and clears everything
    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        bwd_valid_next = bwd_valid_reg;
        mismatch_next  = mismatch_reg;
        fw_en_next     = do_write && !s1_item_reg.last;
        if (s1_valid_reg)
        begin
            if (s1_item_reg.last)
            begin
                fwd_valid_next = '0;
                bwd_valid_next = '0;
                mismatch_next  = 1'b0;
            end
            else
            begin
                mismatch_next = mism_now;
                if (do_write)
                begin
                    fwd_valid_next[s_addr] = 1'b1;
                    bwd_valid_next[t_addr] = 1'b1;
                end
            end
        end
    end

    assign s1_valid_next   = in_valid;
    assign push.valid      = s1_valid_reg && s1_item_reg.last;
    assign push.isomorphic = !mism_now;
    assign last_pending    = s1_valid_reg && s1_item_reg.last;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= '0;
            bwd_valid_reg <= '0;
            mismatch_reg  <= 1'b0;
            fw_en_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            bwd_valid_reg <= bwd_valid_next;
            mismatch_reg  <= mismatch_next;
            fw_en_reg     <= fw_en_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_item_reg <= in_item;
        end
        fw_s_addr_reg <= s_addr;
        fw_t_addr_reg <= t_addr;
        fw_s_byte_reg <= s1_item_reg.s_byte;
        fw_t_byte_reg <= s1_item_reg.t_byte;
    end

    // A bypassed write always belongs to entries that are still valid
    a_fw_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fw_en_reg |-> (fwd_valid_reg[fw_s_addr_reg] && bwd_valid_reg[fw_t_addr_reg]))
        else $error("bypass entry not valid");

    // The last word leaves both maps empty and the flag clear
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.last) |=>
            (!mismatch_reg && fwd_valid_reg == '0 && bwd_valid_reg == '0))
        else $error("state not cleared after last word");

    // Unequal lengths on the last word can never pass
    a_len_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && s1_item_reg.s_present != s1_item_reg.t_present) |-> !push.isomorphic)
        else $error("length mismatch reported as isomorphic");

endmodule

### hw/rtl/bbc_result_fifo.sv
module bbc_result_fifo import bbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    input  logic      last_pending,
    output logic      space_ok,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_isomorphic
);

    logic [RES_DEPTH-1:0] res_q_reg;
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 pop;

    assign out_valid      = (count_reg != '0);
    assign out_isomorphic = res_q_reg[rd_ptr_reg];
    assign pop            = out_valid && out_ready;

    // Credit: room for the verdict in flight plus one more word
    assign space_ok = ((RES_CNT_W+1)'(count_reg) + (RES_CNT_W+1)'(last_pending))
                      < (RES_CNT_W+1)'(RES_DEPTH);

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.valid);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.valid) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            res_q_reg[wr_ptr_reg] <= push.isomorphic;
        end
    end

    // Credit scheme never lets a verdict arrive at a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (count_reg != RES_CNT_W'(RES_DEPTH)))
        else $error("result queue overflow");

endmodule

### tb/byte_bijection_checker_test.sv
// Predicts verdicts from accepted input words and checks them in order
class verdict_board_t;
    logic [bbc_pkg::BYTE_W-1:0] fwd_map [bbc_pkg::MAP_FULL];
    logic [bbc_pkg::BYTE_W-1:0] bwd_map [bbc_pkg::MAP_FULL];
    bit                         fwd_set [bbc_pkg::MAP_FULL];
    bit                         bwd_set [bbc_pkg::MAP_FULL];
    bit                         conflict;
    bit                         verdict_q [$];
    int                         errors;
    int                         checked;
    int                         ones;

    function new();
        foreach (fwd_set[i])
        begin
            fwd_set[i] = 0;
            bwd_set[i] = 0;
        end
        conflict = 0;
        errors   = 0;
        checked  = 0;
        ones     = 0;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    // Update the maps with one accepted word; queue a verdict on last
    function void note_pair(bbc_pkg::pair_t w);
        int a;
        int b;
        a = int'(w.s_byte);
        b = int'(w.t_byte);
        if (w.s_present && w.t_present)
        begin
            if (a >= bbc_pkg::ALPHABET_SIZE_DEF || b >= bbc_pkg::ALPHABET_SIZE_DEF)
                conflict = 1;
            else if (!fwd_set[a] && !bwd_set[b])
            begin
                fwd_map[a] = w.t_byte;
                bwd_map[b] = w.s_byte;
                fwd_set[a] = 1;
                bwd_set[b] = 1;
            end
            else if (!(fwd_set[a] && fwd_map[a] == w.t_byte &&
                       bwd_set[b] && bwd_map[b] == w.s_byte))
                conflict = 1;
        end
        else if (w.s_present != w.t_present)
            conflict = 1;

        if (w.last)
        begin
            verdict_q.push_back(!conflict);
            foreach (fwd_set[i])
            begin
                fwd_set[i] = 0;
                bwd_set[i] = 0;
            end
            conflict = 0;
        end
    endfunction

    // Compare one output word with the oldest expected verdict
    function void check_verdict(logic [bbc_pkg::BYTE_W-1:0] data);
        logic [bbc_pkg::BYTE_W-1:0] want;
        if (verdict_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: output word %h with no verdict pending", data);
            return;
        end
        want = {{(bbc_pkg::BYTE_W-1){1'b0}}, verdict_q.pop_front()};
        checked++;
        if (want[0])
            ones++;
        if (data !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR: verdict %0d: expected isomorphic=%0d (word %h), got %h",
                         checked, want[0], want, data);
        end
    endfunction
endclass

module byte_bijection_checker_test;
    import bbc_pkg::*;

    localparam int IDLE_LIMIT   = 400;
    localparam int RANDOM_WORDS = 1200;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*BYTE_W-1:0] s_tdata  = '0;   // [7:0] s_byte, [15:8] t_byte
    logic [1:0]          s_tuser  = '0;   // [0] s_present, [1] t_present
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [BYTE_W-1:0]   m_tdata;         // [0] isomorphic, [7:1] zero

    verdict_board_t board;
    pair_t          run_q [$];
    logic [7:0]     img  [256];
    logic [7:0]     pool [256];
    bit             tx_calm = 0;
    bit             rx_calm = 0;
    int             words_sent = 0;
    int             busy_words = 0;
    int             idle_cycles = 0;

    byte_bijection_checker #(
        .ALPHABET_SIZE (ALPHABET_SIZE_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function pair_t mk(int sb, int tb, bit sp, bit tp, bit fin);
        pair_t w;
        w.s_byte    = sb[7:0];
        w.t_byte    = tb[7:0];
        w.s_present = sp;
        w.t_present = tp;
        w.last      = fin;
        return w;
    endfunction

    // Drive one word; returns at the edge where it was accepted
    task automatic send_word(pair_t w);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.t_byte, w.s_byte};
        s_tuser  <= {w.t_present, w.s_present};
        s_tlast  <= w.last;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_pair(w);
        words_sent++;
        if (w.s_present || w.t_present || w.last)
            busy_words++;
    endtask

    task automatic send_run();
        for (int i = 0; i < run_q.size(); i++)
            send_word(run_q[i]);
        run_q.delete();
    endtask

    // Fresh random bijection (img) and random byte pool
    task automatic shuffle_maps();
        int j;
        logic [7:0] tmp;
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = img[i]; img[i] = img[j]; img[j] = tmp;
            j = $urandom_range(0, i);
            tmp = pool[i]; pool[i] = pool[j]; pool[j] = tmp;
        end
    endtask

    // Corner cases: empty strings, extreme bytes, both conflict directions,
    // unequal lengths, gaps, continuing after a mismatch
    task automatic build_directed();
        run_q.push_back(mk(8'h00, 8'h00, 0, 0, 1));
        run_q.push_back(mk(8'h00, 8'h00, 1, 1, 1));
        run_q.push_back(mk(8'hFF, 8'h00, 1, 1, 0));
        run_q.push_back(mk(8'h00, 8'hFF, 1, 1, 0));
        run_q.push_back(mk(8'hFF, 8'h00, 1, 1, 1));
        run_q.push_back(mk(1, 2, 1, 1, 0));
        run_q.push_back(mk(1, 3, 1, 1, 1));
        run_q.push_back(mk(1, 2, 1, 1, 0));
        run_q.push_back(mk(3, 2, 1, 1, 1));
        run_q.push_back(mk(5, 6, 1, 1, 0));
        run_q.push_back(mk(7, 0, 1, 0, 1));
        run_q.push_back(mk(5, 6, 1, 1, 0));
        run_q.push_back(mk(0, 9, 0, 1, 1));
        run_q.push_back(mk(10, 20, 1, 1, 0));
        run_q.push_back(mk(8'hAA, 8'h55, 0, 0, 0));
        run_q.push_back(mk(10, 20, 1, 1, 1));
        run_q.push_back(mk(1, 2, 1, 1, 0));
        run_q.push_back(mk(1, 3, 1, 1, 0));
        run_q.push_back(mk(4, 5, 1, 1, 0));
        run_q.push_back(mk(4, 6, 1, 1, 1));
        // maps must be clear again: 1 -> 3 is fresh
        run_q.push_back(mk(1, 3, 1, 1, 1));
        run_q.push_back(mk(8'h3C, 8'h00, 1, 0, 1));
        run_q.push_back(mk(8'hAA, 8'h55, 1, 1, 0));
        run_q.push_back(mk(8'h55, 8'hAA, 0, 0, 1));
    endtask

    // One pair of strings: mostly isomorphic with a chance of damage,
    // sometimes pure noise
    task automatic build_random_run();
        int          kind;
        int          len;
        int          k;
        int          pos;
        int          s;
        bit          alias_on;
        logic [31:0] rnd;
        pair_t       w;
        kind = $urandom_range(0, 99);
        if (kind < 3)
        begin
            run_q.push_back(mk($urandom, $urandom, 0, 0, 1));
            return;
        end
        if (kind < 13)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                rnd = $urandom;
                w = rnd[$bits(pair_t)-1:0];
                w.last = 1'b0;
                run_q.push_back(w);
            end
        end
        else
        begin
            shuffle_maps();
            k   = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                               : $urandom_range(1, 16);
            // two source bytes sharing one image: not injective
            alias_on = (k >= 2) && ($urandom_range(0, 7) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    run_q.push_back(mk($urandom, $urandom, 0, 0, 0));
                s = int'(pool[$urandom_range(0, k - 1)]);
                if (alias_on && s == int'(pool[1]))
                    run_q.push_back(mk(s, int'(img[pool[0]]), 1, 1, 0));
                else
                    run_q.push_back(mk(s, int'(img[s]), 1, 1, 0));
            end
            if ($urandom_range(0, 99) < 35)
            begin
                pos = $urandom_range(0, run_q.size() - 1);
                w = run_q[pos];
                case ($urandom_range(0, 3))
                    0: w.t_byte = 8'($urandom);
                    1: w.s_byte = 8'($urandom);
                    2: if ($urandom_range(0, 1)) w.s_present = 1'b0;
                       else w.t_present = 1'b0;
                    default: ;
                endcase
                run_q[pos] = w;
                if (run_q.size() > 0 && $urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1))
                        run_q.push_back(mk($urandom, $urandom, 1, 0, 0));
                    else
                        run_q.push_back(mk($urandom, $urandom, 0, 1, 0));
                end
            end
        end
        // close the run: flag on the final word or a trailing empty word
        if ($urandom_range(0, 9) == 0)
            run_q.push_back(mk($urandom, $urandom, 0, 0, 1));
        else
        begin
            w = run_q[run_q.size() - 1];
            w.last = 1'b1;
            run_q[run_q.size() - 1] = w;
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        board = new();
        for (int i = 0; i < 256; i++)
        begin
            img[i]  = i[7:0];
            pool[i] = i[7:0];
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        build_directed();
        send_run();

        while (busy_words < RANDOM_WORDS + 24)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            build_random_run();
            send_run();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        rx_calm = 0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d input words; checked %0d verdicts (%0d isomorphic, %0d not).",
                 words_sent, board.checked, board.ones, board.checked - board.ones);
        $display("Runs mixed clean, damaged, unequal-length and noise strings, %0d errors.",
                 board.errors);
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Output side: random stall before each word
    initial
    begin : rx_side
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Verdict check at each output handshake
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_verdict(m_tdata);
    end

    // Watchdog: too long without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end
endmodule
